FILE: src/twg_pkg.sv
// Shared types and constants for the three-mode waveform generator.
package twg_pkg;

   localparam int RAMP_W = 12;
   localparam int CNT_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [RAMP_W-1:0] RAMP_STEP_RST    = 12'd128;
   localparam logic [CNT_W-1:0]  PULSE_HIGH_RST   = 8'd10;
   localparam logic [CNT_W-1:0]  PULSE_PERIOD_RST = 8'd20;

   typedef enum logic [1:0] {
      MODE_PULSE = 2'd0,
      MODE_SAW   = 2'd1,
      MODE_TRI   = 2'd2
   } twg_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RAMP_STEP    = 2'd0,
      CSR_PULSE_HIGH   = 2'd1,
      CSR_PULSE_PERIOD = 2'd2
   } twg_csr_type;

   typedef struct packed {
      logic [RAMP_W-1:0] ramp_step;
      logic [CNT_W-1:0]  pulse_high_ticks;
      logic [CNT_W-1:0]  pulse_period_ticks;
   } twg_cfg_type;

endpackage

FILE: src/twg_req_if.sv
// Input channel: button samples for one tick.
interface twg_req_if;
   logic valid;
   logic ready;
   logic button_now;
   logic button_confirm;

   modport source (output valid, output button_now, output button_confirm, input ready);
   modport sink (input valid, input button_now, input button_confirm, output ready);
endinterface

FILE: src/twg_rsp_if.sv
// Result channel: DAC code, LED level and active mode for one tick.
interface twg_rsp_if #(
   parameter int DAC_BITS = 12
);
   logic                valid;
   logic                ready;
   logic [DAC_BITS-1:0] dac_value;
   logic                led_on;
   logic [1:0]          wave_mode;

   modport source (output valid, output dac_value, output led_on, output wave_mode,
                   input ready);
   modport sink (input valid, input dac_value, input led_on, input wave_mode,
                 output ready);
endinterface

FILE: src/twg_core.sv
// Waveform state and next-sample logic: mode select, pulse, sawtooth, triangle.
module twg_core #(
   parameter int DAC_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                button_now,
   input  logic                button_confirm,
   input  twg_pkg::twg_cfg_type cfg,
   output logic [DAC_BITS-1:0] dac_value,
   output logic                led_on,
   output logic [1:0]          wave_mode
);

   localparam int LEVEL_W =
      ((DAC_BITS > twg_pkg::RAMP_W) ? DAC_BITS : twg_pkg::RAMP_W) + 1;
   localparam logic [DAC_BITS-1:0] FULL = '1;
   localparam logic [LEVEL_W-1:0]  FULL_EXT = LEVEL_W'(FULL);

   twg_pkg::twg_mode_type mode_ff, mode_in;
   logic                       last_ff, last_in;
   logic [twg_pkg::CNT_W-1:0]  pcount_ff, pcount_in;
   logic [DAC_BITS-1:0]        saw_ff, saw_in;
   logic [DAC_BITS-1:0]        tri_ff, tri_in;
   logic                       falling_ff, falling_in;
   logic                       led_ff, led_in;
   logic [DAC_BITS-1:0]        dac_ff, dac_in;

   logic                       press;
   logic [twg_pkg::CNT_W-1:0]  pcount_base, pcount_inc;
   logic [DAC_BITS-1:0]        saw_base, tri_base;
   logic                       falling_base;
   logic [LEVEL_W-1:0]         step_ext, saw_sum, tri_sum, tri_diff;

   always_comb begin
      press    = button_now & ~last_ff & button_confirm;
      step_ext = LEVEL_W'(cfg.ramp_step);

      mode_in = mode_ff;
      led_in  = led_ff;
      if (press) begin
         led_in = ~led_ff;
         case (mode_ff)
            twg_pkg::MODE_PULSE: mode_in = twg_pkg::MODE_SAW;
            twg_pkg::MODE_SAW:   mode_in = twg_pkg::MODE_TRI;
            default:             mode_in = twg_pkg::MODE_PULSE;
         endcase
      end
      last_in = button_now;

      // a confirmed press restarts every waveform from zero
      pcount_base  = press ? '0 : pcount_ff;
      saw_base     = press ? '0 : saw_ff;
      tri_base     = press ? '0 : tri_ff;
      falling_base = press ? 1'b0 : falling_ff;

      pcount_inc = pcount_base + 1'b1;
      saw_sum    = LEVEL_W'(saw_base) + step_ext;
      tri_sum    = LEVEL_W'(tri_base) + step_ext;
      tri_diff   = LEVEL_W'(tri_base) - step_ext;

      pcount_in  = pcount_base;
      saw_in     = saw_base;
      tri_in     = tri_base;
      falling_in = falling_base;
      dac_in     = dac_ff;

      case (mode_in)
         twg_pkg::MODE_PULSE: begin
            pcount_in = pcount_inc;
            if (pcount_inc < cfg.pulse_high_ticks) begin
               dac_in = FULL;
            end else if (pcount_inc < cfg.pulse_period_ticks) begin
               dac_in = '0;
            end else begin
               pcount_in = '0;   // end of period: DAC holds its code
            end
         end
         twg_pkg::MODE_SAW: begin
            saw_in = (saw_sum > FULL_EXT) ? '0 : saw_sum[DAC_BITS-1:0];
            dac_in = saw_in;
         end
         twg_pkg::MODE_TRI: begin
            if (!falling_base) begin
               if (tri_sum >= FULL_EXT) begin
                  tri_in     = FULL;
                  falling_in = 1'b1;
               end else begin
                  tri_in = tri_sum[DAC_BITS-1:0];
               end
            end else begin
               if (LEVEL_W'(tri_base) <= step_ext) begin
                  tri_in     = '0;
                  falling_in = 1'b0;
               end else begin
                  tri_in = tri_diff[DAC_BITS-1:0];
               end
            end
            dac_in = tri_in;
         end
         default: dac_in = dac_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= twg_pkg::MODE_PULSE;
         last_ff    <= 1'b0;
         pcount_ff  <= '0;
         saw_ff     <= '0;
         tri_ff     <= '0;
         falling_ff <= 1'b0;
         led_ff     <= 1'b0;
         dac_ff     <= '0;
      end else if (advance) begin
         mode_ff    <= mode_in;
         last_ff    <= last_in;
         pcount_ff  <= pcount_in;
         saw_ff     <= saw_in;
         tri_ff     <= tri_in;
         falling_ff <= falling_in;
         led_ff     <= led_in;
         dac_ff     <= dac_in;
      end
   end

   assign dac_value = dac_in;
   assign led_on    = led_in;
   assign wave_mode = mode_in;

   a_press_toggles_led: assert property (@(posedge clock) disable iff (reset)
      advance && press |=> led_ff != $past(led_ff))
      else $error("confirmed press did not toggle LED");

   a_idle_holds_state: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(mode_ff) && $stable(dac_ff) && $stable(led_ff)
                   && $stable(tri_ff) && $stable(saw_ff))
      else $error("waveform state changed without an item");

   a_tri_full_falls: assert property (@(posedge clock) disable iff (reset)
      advance && mode_in == twg_pkg::MODE_TRI && !falling_base && tri_sum >= FULL_EXT
      |=> falling_ff && tri_ff == FULL)
      else $error("triangle did not turn at full scale");

endmodule

FILE: src/three_mode_waveform_generator.sv
// Three-mode waveform generator: one button-sample item in, one DAC sample item out.
// Accepts one item per clock while results are taken: the item is registered
// at the input, the mode, pulse, sawtooth and triangle update is worked out in
// one pass of adders and comparators, and the result lands in an output
// register. While a result is stalled, one more item can still enter the input
// register; after that req ready stays low until the result is taken. The user
// must write the csr_ registers (ramp step, pulse high count, pulse period)
// only while idle; the block itself does not enforce this.
module three_mode_waveform_generator #(
   parameter int DAC_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   twg_req_if.sink                         req_chan,
   twg_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [twg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [twg_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   twg_pkg::twg_cfg_type cfg_ff;

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_now_ff, s1_confirm_ff;
   logic                out_valid_ff, out_valid_in;
   logic [DAC_BITS-1:0] out_dac_ff;
   logic                out_led_ff;
   logic [1:0]          out_mode_ff;

   logic                out_free, advance, req_take;
   logic [DAC_BITS-1:0] dac_next;
   logic                led_next;
   logic [1:0]          mode_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_step          <= twg_pkg::RAMP_STEP_RST;
         cfg_ff.pulse_high_ticks   <= twg_pkg::PULSE_HIGH_RST;
         cfg_ff.pulse_period_ticks <= twg_pkg::PULSE_PERIOD_RST;
      end else if (csr_we) begin
         case (csr_index)
            twg_pkg::CSR_RAMP_STEP:
               cfg_ff.ramp_step <= csr_wdata[twg_pkg::RAMP_W-1:0];
            twg_pkg::CSR_PULSE_HIGH:
               cfg_ff.pulse_high_ticks <= csr_wdata[twg_pkg::CNT_W-1:0];
            twg_pkg::CSR_PULSE_PERIOD:
               cfg_ff.pulse_period_ticks <= csr_wdata[twg_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_now_ff     <= req_chan.button_now;
         s1_confirm_ff <= req_chan.button_confirm;
      end
      if (advance) begin
         out_dac_ff  <= dac_next;
         out_led_ff  <= led_next;
         out_mode_ff <= mode_next;
      end
   end

   twg_core #(
      .DAC_BITS (DAC_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .button_now     (s1_now_ff),
      .button_confirm (s1_confirm_ff),
      .cfg            (cfg_ff),
      .dac_value      (dac_next),
      .led_on         (led_next),
      .wave_mode      (mode_next)
   );

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.dac_value = out_dac_ff;
   assign rsp_chan.led_on    = out_led_ff;
   assign rsp_chan.wave_mode = out_mode_ff;

   a_s1_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_now_ff)
                                   && $stable(s1_confirm_ff))
      else $error("input stage lost an item while the output was stalled");

   a_out_from_stage: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff && !s1_valid_ff |=> !out_valid_ff)
      else $error("result appeared without an item in the input stage");

   a_take_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced item did not reach the output register");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the three-mode waveform generator.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DAC_BITS = 12;
   localparam logic [DAC_BITS-1:0] FULL_SCALE = '1;
   localparam int PHASE_ITEMS = 140;
   localparam int NUM_PHASES = 8;
   localparam int SCRIPT_LEN = 25;

   typedef struct packed {
      logic [DAC_BITS-1:0]   dac;
      logic                  led;
      twg_pkg::twg_mode_type mode;
   } dac_sample_type;

   typedef struct {
      logic                  now;
      logic                  confirm;
      bit                    by_hand;
      logic [DAC_BITS-1:0]   dac;
      logic                  led;
      twg_pkg::twg_mode_type mode;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [twg_pkg::CSR_IDX_W-1:0] csr_index;
   logic [twg_pkg::CSR_DATA_W-1:0] csr_wdata;

   twg_req_if req_chan();
   twg_rsp_if #(.DAC_BITS(DAC_BITS)) rsp_chan();

   three_mode_waveform_generator #(.DAC_BITS(DAC_BITS)) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // generator state as seen from outside
   twg_pkg::twg_cfg_type         cfg_now;
   twg_pkg::twg_mode_type        mode_q;
   logic                         btn_last_q;
   logic                         tri_down_q;
   logic                         led_q;
   logic [twg_pkg::CNT_W-1:0]    pulse_cnt_q;
   logic [twg_pkg::RAMP_W:0]     saw_q;
   logic [twg_pkg::RAMP_W:0]     tri_q;
   logic [DAC_BITS-1:0]          dac_q;

   dac_sample_type pending_samples[$];
   int errors = 0;
   bit quiet_phase = 1'b0;

   // Button walk-through from reset with default settings; rows marked by hand
   // carry their result, the rest go through the predictor.
   script_row_type press_script [SCRIPT_LEN] = '{
      '{1'b0, 1'b0, 1'b1, 12'd4095, 1'b0, twg_pkg::MODE_PULSE},
      '{1'b1, 1'b0, 1'b1, 12'd4095, 1'b0, twg_pkg::MODE_PULSE},
      '{1'b0, 1'b1, 1'b1, 12'd4095, 1'b0, twg_pkg::MODE_PULSE},
      '{1'b1, 1'b1, 1'b1, 12'd128,  1'b1, twg_pkg::MODE_SAW},
      '{1'b1, 1'b1, 1'b1, 12'd256,  1'b1, twg_pkg::MODE_SAW},
      '{1'b0, 1'b0, 1'b1, 12'd384,  1'b1, twg_pkg::MODE_SAW},
      '{1'b1, 1'b1, 1'b1, 12'd128,  1'b0, twg_pkg::MODE_TRI},
      '{1'b0, 1'b0, 1'b1, 12'd256,  1'b0, twg_pkg::MODE_TRI},
      '{1'b1, 1'b1, 1'b1, 12'd4095, 1'b1, twg_pkg::MODE_PULSE},
      '{1'b0, 1'b0, 1'b0, 12'd0,    1'b0, twg_pkg::MODE_PULSE},
      '{1'b0, 1'b0, 1'b0, 12'd0,    1'b0, twg_pkg::MODE_PULSE},
      '{1'b0, 1'b0, 1'b0, 12'd0,    1'b0, twg_pkg::MODE_PULSE},
      '{1'b0, 1'b0, 1'b0, 12'd0,    1'b0, twg_pkg::MODE_PULSE},
      '{1'b0, 1'b0, 1'b0, 12'd0,    1'b0, twg_pkg::MODE_PULSE},
      '{1'b0, 1'b0, 1'b0, 12'd0,    1'b0, twg_pkg::MODE_PULSE},
      '{1'b0, 1'b0, 1'b0, 12'd0,    1'b0, twg_pkg::MODE_PULSE},
      '{1'b0, 1'b0, 1'b0, 12'd0,    1'b0, twg_pkg::MODE_PULSE},
      '{1'b0, 1'b0, 1'b0, 12'd0,    1'b0, twg_pkg::MODE_PULSE},
      '{1'b0, 1'b0, 1'b0, 12'd0,    1'b0, twg_pkg::MODE_PULSE},
      '{1'b1, 1'b0, 1'b0, 12'd0,    1'b0, twg_pkg::MODE_PULSE},
      '{1'b0, 1'b1, 1'b0, 12'd0,    1'b0, twg_pkg::MODE_PULSE},
      '{1'b1, 1'b1, 1'b0, 12'd0,    1'b0, twg_pkg::MODE_PULSE},
      '{1'b0, 1'b0, 1'b0, 12'd0,    1'b0, twg_pkg::MODE_PULSE},
      '{1'b1, 1'b0, 1'b0, 12'd0,    1'b0, twg_pkg::MODE_PULSE},
      '{1'b0, 1'b0, 1'b0, 12'd0,    1'b0, twg_pkg::MODE_PULSE}
   };

   function automatic void reset_generator();
      cfg_now = '{twg_pkg::RAMP_STEP_RST, twg_pkg::PULSE_HIGH_RST,
                  twg_pkg::PULSE_PERIOD_RST};
      mode_q = twg_pkg::MODE_PULSE;
      btn_last_q = 1'b0;
      tri_down_q = 1'b0;
      led_q = 1'b0;
      pulse_cnt_q = '0;
      saw_q = '0;
      tri_q = '0;
      dac_q = '0;
   endfunction

   function automatic dac_sample_type advance_generator(logic now, logic confirm);
      dac_sample_type s;
      if (now && !btn_last_q && confirm) begin
         case (mode_q)
            twg_pkg::MODE_PULSE: mode_q = twg_pkg::MODE_SAW;
            twg_pkg::MODE_SAW:   mode_q = twg_pkg::MODE_TRI;
            default:             mode_q = twg_pkg::MODE_PULSE;
         endcase
         led_q = !led_q;
         pulse_cnt_q = '0;
         saw_q = '0;
         tri_q = '0;
         tri_down_q = 1'b0;
      end
      btn_last_q = now;
      case (mode_q)
         twg_pkg::MODE_PULSE: begin
            pulse_cnt_q = pulse_cnt_q + 1'b1;
            if (pulse_cnt_q < cfg_now.pulse_high_ticks)
               dac_q = FULL_SCALE;
            else if (pulse_cnt_q < cfg_now.pulse_period_ticks)
               dac_q = '0;
            else
               pulse_cnt_q = '0;  // period reached: DAC keeps its code
         end
         twg_pkg::MODE_SAW: begin
            saw_q = saw_q + cfg_now.ramp_step;
            if (saw_q > FULL_SCALE)
               saw_q = '0;
            dac_q = saw_q[DAC_BITS-1:0];
         end
         twg_pkg::MODE_TRI: begin
            if (!tri_down_q) begin
               tri_q = tri_q + cfg_now.ramp_step;
               if (tri_q >= FULL_SCALE) begin
                  tri_q = FULL_SCALE;
                  tri_down_q = 1'b1;
               end
            end else if (tri_q <= cfg_now.ramp_step) begin
               tri_q = '0;
               tri_down_q = 1'b0;
            end else begin
               tri_q = tri_q - cfg_now.ramp_step;
            end
            dac_q = tri_q[DAC_BITS-1:0];
         end
         default: ;
      endcase
      s.dac = dac_q;
      s.led = led_q;
      s.mode = mode_q;
      return s;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (quiet_phase)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   task automatic send_tick(input logic now, input logic confirm, input bit by_hand,
                            input dac_sample_type hand);
      int gap;
      dac_sample_type due;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.button_now <= now;
      req_chan.button_confirm <= confirm;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      due = advance_generator(now, confirm);
      pending_samples.push_back(by_hand ? hand : due);
   endtask

   task automatic drain_samples();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_samples.size() != 0) @(posedge clock);
   endtask

   // upper bits of the 8-bit registers' write data are don't-care noise
   task automatic load_settings(input twg_pkg::twg_cfg_type c);
      csr_we <= 1'b1;
      csr_index <= twg_pkg::CSR_RAMP_STEP;
      csr_wdata <= c.ramp_step;
      @(posedge clock);
      csr_index <= twg_pkg::CSR_PULSE_HIGH;
      csr_wdata <= {4'($urandom), c.pulse_high_ticks};
      @(posedge clock);
      csr_index <= twg_pkg::CSR_PULSE_PERIOD;
      csr_wdata <= {4'($urandom), c.pulse_period_ticks};
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_now = c;
   endtask

   task automatic check_sample();
      dac_sample_type want;
      if (pending_samples.size() == 0) begin
         $error("unexpected item: dac_value %0d led_on %0d wave_mode %0d",
                rsp_chan.dac_value, rsp_chan.led_on, rsp_chan.wave_mode);
         errors++;
      end else begin
         want = pending_samples.pop_front();
         if (rsp_chan.dac_value !== want.dac) begin
            $error("dac_value: expected %0d, got %0d", want.dac, rsp_chan.dac_value);
            errors++;
         end
         if (rsp_chan.led_on !== want.led) begin
            $error("led_on: expected %0d, got %0d", want.led, rsp_chan.led_on);
            errors++;
         end
         if (rsp_chan.wave_mode !== want.mode) begin
            $error("wave_mode: expected %0d, got %0d", want.mode, rsp_chan.wave_mode);
            errors++;
         end
      end
   endtask

   initial begin : result_side
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         if (rsp_chan.valid)
            check_sample();
      end
   end

   initial begin : stimulus
      twg_pkg::twg_cfg_type settings [NUM_PHASES];
      dac_sample_type hand;
      logic now;
      logic confirm;
      int held;
      int r;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= twg_pkg::CSR_RAMP_STEP;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.button_now <= 1'b0;
      req_chan.button_confirm <= 1'b0;
      reset_generator();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (press_script[i]) begin
         hand.dac = press_script[i].dac;
         hand.led = press_script[i].led;
         hand.mode = press_script[i].mode;
         send_tick(press_script[i].now, press_script[i].confirm, press_script[i].by_hand,
                   hand);
      end
      drain_samples();

      // extremes, zero step, period 0 and 1, high count past the period
      settings[0] = '{12'd4095, 8'd255, 8'd255};
      settings[1] = '{12'd1, 8'd1, 8'd2};
      settings[2] = '{12'd0, 8'd0, 8'd0};
      settings[3] = '{12'd2048, 8'd200, 8'd100};
      settings[4] = '{12'd300, 8'd3, 8'd1};
      settings[5] = '{12'($urandom_range(1, 4095)), 8'($urandom_range(1, 255)),
                      8'($urandom_range(2, 255))};
      settings[6] = '{12'($urandom_range(64, 1024)), 8'($urandom_range(1, 40)),
                      8'($urandom_range(2, 60))};
      settings[7] = '{twg_pkg::RAMP_STEP_RST, twg_pkg::PULSE_HIGH_RST,
                      twg_pkg::PULSE_PERIOD_RST};

      for (int p = 0; p < NUM_PHASES; p++) begin
         quiet_phase = p[0];
         load_settings(settings[p]);
         held = 0;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k == PHASE_ITEMS / 2)
               drain_samples();
            r = $urandom_range(0, 99);
            if (held > 0) begin
               // button kept down; confirm sample may chatter
               held--;
               now = 1'b1;
               confirm = 1'($urandom_range(0, 1));
            end else if (r < 2) begin
               now = 1'b1;
               confirm = ($urandom_range(0, 3) != 0);
               held = $urandom_range(0, 4);
            end else if (r < 7) begin
               // bounce that the debounce sample rejects
               now = 1'b1;
               confirm = 1'b0;
            end else if (r < 10) begin
               now = 1'($urandom_range(0, 1));
               confirm = 1'($urandom_range(0, 1));
            end else begin
               now = 1'b0;
               confirm = 1'b0;
            end
            send_tick(now, confirm, 1'b0, '0);
         end
         drain_samples();
      end

      repeat (4) @(posedge clock);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin : watchdog
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
